@@ hdl/ssflt_pkg.sv @@
// ============================================================================
// ssflt_pkg
// Shared types and constants for the sorted symbol floor lookup table.
// ============================================================================
package ssflt_pkg;

    localparam int DEFAULT_TABLE_DEPTH      = 1024;
    localparam int DEFAULT_NAME_HANDLE_BITS = 16;
    localparam int ADDR_W   = 64;
    localparam int NAME_W   = 16;
    localparam int KIND_W   = 2;
    localparam int BIND_W   = 3;
    localparam int OP_W     = 2;
    localparam int COUNT_W  = 11;

    localparam logic [OP_W-1:0] OP_ADD      = 2'd0;
    localparam logic [OP_W-1:0] OP_COALESCE = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP   = 2'd2;

    // Commands from the controller to the datapath.
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_START,     // latch the input item
        CMD_RD_LAST,   // read entry at scan index (idx - 1)
        CMD_SHIFT,     // move entry up one slot
        CMD_PLACE,     // write new entry at idx
        CMD_RD_FIRST,  // read entry 0 for lookup/coalesce
        CMD_RD_MID,    // read entry at middle of search window
        CMD_STEP,      // update window from compare
        CMD_RD_HIT,    // read entry at lo
        CMD_CO_RD_IN,  // read entry at scan input index
        CMD_CO_WRITE,  // write merged / moved entry at output index
        CMD_CO_DONE,   // set count to output index + 1
        CMD_RESULT     // load the result registers
    } cmd_t;

    typedef struct packed {
        logic       is_add;
        logic       is_coalesce;
        logic       is_lookup;
        logic       full;
        logic       empty;
        logic       shift_more;   // idx > 0 and stored address > new address
        logic       search_more;  // hi - lo > 1
        logic       below_first;  // query below entry 0
        logic       scan_more;    // input index < used entries
        logic       hit;
    } status_t;

endpackage

@@ hdl/ssflt_datapath.sv @@
// ============================================================================
// ssflt_datapath
// Entry memories, index registers, compare and merge logic.
// ============================================================================
module ssflt_datapath #(
    parameter int TABLE_DEPTH      = ssflt_pkg::DEFAULT_TABLE_DEPTH,
    parameter int NAME_HANDLE_BITS = ssflt_pkg::DEFAULT_NAME_HANDLE_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  ssflt_pkg::cmd_t                    cmd,
    output ssflt_pkg::status_t                 status,
    input  logic [ssflt_pkg::OP_W-1:0]         operation,
    input  logic [ssflt_pkg::ADDR_W-1:0]       sym_address,
    input  logic [ssflt_pkg::NAME_W-1:0]       name_id,
    input  logic [ssflt_pkg::KIND_W-1:0]       sym_kind,
    input  logic [ssflt_pkg::BIND_W-1:0]       sym_binding,
    input  logic                               name_is_pseudo,
    input  logic                               name_is_low_level,
    output logic                               found,
    output logic [ssflt_pkg::ADDR_W-1:0]       hit_address,
    output logic [ssflt_pkg::NAME_W-1:0]       hit_name_id,
    output logic [ssflt_pkg::KIND_W-1:0]       hit_kind,
    output logic [ssflt_pkg::BIND_W-1:0]       hit_binding,
    output logic [ssflt_pkg::COUNT_W-1:0]      entry_count,
    output logic                               rejected
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int NW    = NAME_HANDLE_BITS;
    localparam int ATTR_W = NW + 7;

    // Attribute layout: {low, pseudo, binding, kind, name}.
    typedef logic [ATTR_W-1:0] attr_t;

    logic [ssflt_pkg::ADDR_W-1:0] addr_mem [TABLE_DEPTH];
    attr_t                        attr_mem [TABLE_DEPTH];

    logic [ssflt_pkg::OP_W-1:0]   op_reg;
    logic [ssflt_pkg::ADDR_W-1:0] key_reg;
    attr_t                        new_attr_reg;
    logic [CNT_W-1:0]             used_reg;
    logic [CNT_W-1:0]             idx_reg;   // add scan position, coalesce input
    logic [CNT_W-1:0]             lo_reg;    // also coalesce output index
    logic [CNT_W-1:0]             hi_reg;
    logic [ssflt_pkg::ADDR_W-1:0] rd_addr_reg;
    attr_t                        rd_attr_reg;
    logic [ssflt_pkg::ADDR_W-1:0] keep_addr_reg;
    attr_t                        keep_attr_reg;
    logic                         found_reg;
    logic                         rej_reg;   // add arrived with the table full

    logic [CNT_W-1:0] mid;
    logic [CNT_W-1:0] rd_idx;
    logic             rd_en;
    logic [CNT_W-1:0] wr_idx;
    logic             wr_en;
    logic [ssflt_pkg::ADDR_W-1:0] wr_addr;
    attr_t                        wr_attr;
    attr_t                        merged;
    logic [CNT_W-1:0] lo_inc;

    assign mid    = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign lo_inc = lo_reg + CNT_W'(1);

    // Highest-binding merge of the kept entry with a later equal entry.
    always_comb
    begin
        logic [2:0] lb;
        logic [2:0] rb;
        lb = keep_attr_reg[NW+4:NW+2];
        rb = rd_attr_reg[NW+4:NW+2];
        merged = keep_attr_reg;
        if (lb < rb)
        begin
            merged = rd_attr_reg;
        end
        else if (lb == rb && (keep_attr_reg[NW+5] || rd_attr_reg[NW+6]))
        begin
            merged = {rd_attr_reg[NW+6:NW+5], keep_attr_reg[NW+4:NW], rd_attr_reg[NW-1:0]};
        end
    end

    always_comb
    begin
        rd_en   = 1'b0;
        rd_idx  = '0;
        wr_en   = 1'b0;
        wr_idx  = idx_reg;
        wr_addr = rd_addr_reg;
        wr_attr = rd_attr_reg;
        case (cmd)
            ssflt_pkg::CMD_RD_LAST:  begin rd_en = 1'b1; rd_idx = idx_reg - CNT_W'(1); end
            ssflt_pkg::CMD_SHIFT:    begin wr_en = 1'b1; wr_idx = idx_reg; end
            ssflt_pkg::CMD_PLACE:
            begin
                wr_en = 1'b1;
                wr_addr = key_reg;
                wr_attr = new_attr_reg;
            end
            ssflt_pkg::CMD_RD_FIRST: begin rd_en = 1'b1; rd_idx = '0; end
            ssflt_pkg::CMD_RD_MID:   begin rd_en = 1'b1; rd_idx = mid; end
            ssflt_pkg::CMD_RD_HIT:   begin rd_en = 1'b1; rd_idx = lo_reg; end
            ssflt_pkg::CMD_CO_RD_IN: begin rd_en = 1'b1; rd_idx = idx_reg; end
            ssflt_pkg::CMD_CO_WRITE:
            begin
                wr_en = 1'b1;
                if (keep_addr_reg == rd_addr_reg)
                begin
                    wr_idx = lo_reg;
                    wr_addr = keep_addr_reg;
                    wr_attr = merged;
                end
                else
                begin
                    wr_idx = lo_inc;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            addr_mem[wr_idx[IDX_W-1:0]] <= wr_addr;
            attr_mem[wr_idx[IDX_W-1:0]] <= wr_attr;
        end
        if (rd_en)
        begin
            rd_addr_reg <= addr_mem[rd_idx[IDX_W-1:0]];
            rd_attr_reg <= attr_mem[rd_idx[IDX_W-1:0]];
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        case (cmd)
            ssflt_pkg::CMD_START:
            begin
                op_reg       <= operation;
                key_reg      <= sym_address;
                new_attr_reg <= {name_is_low_level, name_is_pseudo, sym_binding,
                                 sym_kind, NW'(name_id)};
            end
            ssflt_pkg::CMD_CO_WRITE:
            begin
                if (keep_addr_reg == rd_addr_reg)
                begin
                    keep_attr_reg <= merged;
                end
                else
                begin
                    keep_addr_reg <= rd_addr_reg;
                    keep_attr_reg <= rd_attr_reg;
                end
            end
            ssflt_pkg::CMD_RD_MID:
            begin
                // Entry 0 lands here on the first CMD_RD_MID after CMD_RD_FIRST.
                keep_addr_reg <= rd_addr_reg;
                keep_attr_reg <= rd_attr_reg;
            end
            ssflt_pkg::CMD_RESULT:
            begin
                hit_address <= found_reg ? rd_addr_reg : '0;
                hit_name_id <= found_reg ? ssflt_pkg::NAME_W'(rd_attr_reg[NW-1:0]) : '0;
                hit_kind    <= found_reg ? rd_attr_reg[NW+1:NW] : '0;
                hit_binding <= found_reg ? rd_attr_reg[NW+4:NW+2] : '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg    <= '0;
            idx_reg     <= '0;
            lo_reg      <= '0;
            hi_reg      <= '0;
            found_reg   <= 1'b0;
            rej_reg     <= 1'b0;
            found       <= 1'b0;
            rejected    <= 1'b0;
            entry_count <= '0;
        end
        else
        begin
            case (cmd)
                ssflt_pkg::CMD_START:
                begin
                    idx_reg   <= (operation == ssflt_pkg::OP_COALESCE) ? CNT_W'(1) : used_reg;
                    lo_reg    <= '0;
                    hi_reg    <= used_reg;
                    found_reg <= 1'b0;
                    rej_reg   <= (operation == ssflt_pkg::OP_ADD) &&
                                 (used_reg == CNT_W'(TABLE_DEPTH));
                end
                ssflt_pkg::CMD_SHIFT: idx_reg <= idx_reg - CNT_W'(1);
                ssflt_pkg::CMD_PLACE: used_reg <= used_reg + CNT_W'(1);
                // Coalesce also passes through here to load the kept entry.
                ssflt_pkg::CMD_RD_MID: found_reg <= (op_reg == ssflt_pkg::OP_LOOKUP);
                ssflt_pkg::CMD_STEP:
                begin
                    if (rd_addr_reg <= key_reg)
                        lo_reg <= mid;
                    else
                        hi_reg <= mid;
                end
                ssflt_pkg::CMD_CO_WRITE:
                begin
                    idx_reg <= idx_reg + CNT_W'(1);
                    if (keep_addr_reg != rd_addr_reg)
                        lo_reg <= lo_inc;
                end
                ssflt_pkg::CMD_CO_DONE: used_reg <= lo_inc;
                ssflt_pkg::CMD_RESULT:
                begin
                    found       <= found_reg;
                    rejected    <= rej_reg;
                    entry_count <= ssflt_pkg::COUNT_W'(used_reg);
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        status.is_add      = (op_reg == ssflt_pkg::OP_ADD);
        status.is_coalesce = (op_reg == ssflt_pkg::OP_COALESCE);
        status.is_lookup   = (op_reg == ssflt_pkg::OP_LOOKUP);
        status.full        = (used_reg == CNT_W'(TABLE_DEPTH));
        status.empty       = (used_reg == '0);
        status.shift_more  = (idx_reg != '0) && (rd_addr_reg > key_reg);
        status.search_more = ((hi_reg - lo_reg) > CNT_W'(1));
        status.below_first = (key_reg < rd_addr_reg);
        status.scan_more   = (idx_reg < used_reg);
        status.hit         = found_reg;
    end

endmodule

@@ hdl/ssflt_ctrl.sv @@
// ============================================================================
// ssflt_ctrl
// Sequencer that steps the datapath through add, coalesce and lookup.
// ============================================================================
module ssflt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  ssflt_pkg::status_t status,
    output ssflt_pkg::cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_ADD_RD, S_ADD_WAIT, S_ADD_CHK, S_FIRST_WAIT,
        S_FIRST_CHK, S_MID_WAIT, S_STEP, S_HIT_WAIT, S_CO_RD, S_CO_WAIT,
        S_RESULT, S_OUT
    } state_t;

    state_t state_reg;

    assign in_ready = (state_reg == S_IDLE) || (state_reg == S_OUT && out_ready);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        cmd = ssflt_pkg::CMD_NONE;
        case (state_reg)
            S_IDLE:       if (in_valid) cmd = ssflt_pkg::CMD_START;
            S_OUT:        if (out_ready && in_valid) cmd = ssflt_pkg::CMD_START;
            S_ADD_RD:     cmd = ssflt_pkg::CMD_RD_LAST;
            S_ADD_CHK:    cmd = status.shift_more ? ssflt_pkg::CMD_SHIFT : ssflt_pkg::CMD_PLACE;
            S_DECODE:
            begin
                if (status.is_add && !status.full && status.empty)
                    cmd = ssflt_pkg::CMD_PLACE;
                else if ((status.is_lookup || status.is_coalesce) && !status.empty)
                    cmd = ssflt_pkg::CMD_RD_FIRST;
            end
            S_FIRST_CHK:
            begin
                if (status.is_coalesce)
                    cmd = ssflt_pkg::CMD_RD_MID;  // loads kept entry
                else if (!status.below_first)
                    cmd = ssflt_pkg::CMD_RD_MID;
            end
            S_MID_WAIT:   cmd = ssflt_pkg::CMD_STEP;
            S_STEP:       cmd = status.search_more ? ssflt_pkg::CMD_RD_MID
                                                   : ssflt_pkg::CMD_RD_HIT;
            S_CO_RD:      if (status.scan_more) cmd = ssflt_pkg::CMD_CO_RD_IN;
                          else cmd = ssflt_pkg::CMD_CO_DONE;
            S_CO_WAIT:    cmd = ssflt_pkg::CMD_CO_WRITE;
            S_RESULT:     cmd = ssflt_pkg::CMD_RESULT;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            case (state_reg)
                S_IDLE:   if (in_valid) state_reg <= S_DECODE;
                S_OUT:
                begin
                    if (out_ready)
                        state_reg <= in_valid ? S_DECODE : S_IDLE;
                end
                S_DECODE:
                begin
                    if (status.is_add && !status.full)
                        state_reg <= status.empty ? S_RESULT : S_ADD_RD;
                    else if ((status.is_lookup || status.is_coalesce) && !status.empty)
                        state_reg <= S_FIRST_WAIT;
                    else
                        state_reg <= S_RESULT;
                end
                S_ADD_RD:     state_reg <= S_ADD_WAIT;
                S_ADD_WAIT:   state_reg <= S_ADD_CHK;
                S_ADD_CHK:
                begin
                    if (!status.shift_more)
                        state_reg <= S_RESULT;
                    else
                        state_reg <= S_ADD_RD;
                end
                S_FIRST_WAIT: state_reg <= S_FIRST_CHK;
                S_FIRST_CHK:
                begin
                    if (status.is_coalesce)
                        state_reg <= S_CO_RD;
                    else if (status.below_first)
                        state_reg <= S_RESULT;
                    else
                        state_reg <= S_MID_WAIT;
                end
                S_MID_WAIT:   state_reg <= S_STEP;
                S_STEP:       state_reg <= status.search_more ? S_MID_WAIT : S_HIT_WAIT;
                S_HIT_WAIT:   state_reg <= S_RESULT;
                S_CO_RD:      state_reg <= status.scan_more ? S_CO_WAIT : S_RESULT;
                S_CO_WAIT:    state_reg <= S_CO_RD;
                S_RESULT:     state_reg <= S_OUT;
                default:      state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE && state_reg != S_OUT) |-> !in_ready)
        else $error("input accepted while busy");
    a_out_follows_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_RESULT))
        else $error("result shown without result load");
    a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESULT) |=> (state_reg == S_OUT))
        else $error("result stage not followed by output");
    a_hit_only_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        status.hit |-> status.is_lookup)
        else $error("hit flag set outside a lookup");
`endif

endmodule

@@ hdl/sorted_symbol_floor_lookup_table.sv @@
// ============================================================================
// sorted_symbol_floor_lookup_table
// Sorted symbol table with insert, coalesce and floor lookup.
// ============================================================================
// The table holds up to TABLE_DEPTH symbols sorted by start address in two
// single-port memories (address and attributes) with registered reads. Every
// item gives exactly one result. Timing is set by the memory port, which
// serves one access per step: a lookup is a binary search with one read and
// one compare per level, an add reads and moves up one slot each entry that
// lies above the new address, and a coalesce reads each stored entry once. A
// new item is taken in the same cycle the previous result is handed over. The
// memories need no clearing after reset; only entries below the count ever
// affect a result.
module sorted_symbol_floor_lookup_table #(
    parameter int TABLE_DEPTH      = ssflt_pkg::DEFAULT_TABLE_DEPTH,
    parameter int NAME_HANDLE_BITS = ssflt_pkg::DEFAULT_NAME_HANDLE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ssflt_pkg::OP_W-1:0]    operation,
    input  logic [ssflt_pkg::ADDR_W-1:0]  sym_address,
    input  logic [ssflt_pkg::NAME_W-1:0]  name_id,
    input  logic [ssflt_pkg::KIND_W-1:0]  sym_kind,
    input  logic [ssflt_pkg::BIND_W-1:0]  sym_binding,
    input  logic                          name_is_pseudo,
    input  logic                          name_is_low_level,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          found,
    output logic [ssflt_pkg::ADDR_W-1:0]  hit_address,
    output logic [ssflt_pkg::NAME_W-1:0]  hit_name_id,
    output logic [ssflt_pkg::KIND_W-1:0]  hit_kind,
    output logic [ssflt_pkg::BIND_W-1:0]  hit_binding,
    output logic [ssflt_pkg::COUNT_W-1:0] entry_count,
    output logic                          rejected
);

    ssflt_pkg::cmd_t    cmd;
    ssflt_pkg::status_t status;

    // The controller sequences memory accesses; the datapath owns all storage.
    ssflt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    ssflt_datapath #(
        .TABLE_DEPTH      (TABLE_DEPTH),
        .NAME_HANDLE_BITS (NAME_HANDLE_BITS)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .operation         (operation),
        .sym_address       (sym_address),
        .name_id           (name_id),
        .sym_kind          (sym_kind),
        .sym_binding       (sym_binding),
        .name_is_pseudo    (name_is_pseudo),
        .name_is_low_level (name_is_low_level),
        .found             (found),
        .hit_address       (hit_address),
        .hit_name_id       (hit_name_id),
        .hit_kind          (hit_kind),
        .hit_binding       (hit_binding),
        .entry_count       (entry_count),
        .rejected          (rejected)
    );

endmodule
